[sv/sat_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sat_pkg;

   // item kinds on the request side
   localparam logic [1:0] KIND_VERT_A   = 2'd0;
   localparam logic [1:0] KIND_VERT_B   = 2'd1;
   localparam logic [1:0] KIND_CENTRE_A = 2'd2;
   localparam logic [1:0] KIND_RUN      = 2'd3;

   localparam int COORD_W = 32;
   localparam int NORM_W  = 16;
   localparam int DEPTH_W = 32;
   localparam int PROJ_W  = 50;
   localparam int OV_W    = 51;

   // integer square root of the squared edge length
   localparam int SQRT_IN_W   = 62;
   localparam int ROOT_W      = 31;
   localparam int SQRT_STEPS  = 31;

   // normal component divide: quotient never exceeds 2^15
   localparam int DIV_NUM_W   = 46;
   localparam int DIV_DEN_W   = 31;
   localparam int QUO_W       = 17;
   localparam int DIV_STEPS   = 17;

   localparam int STEP_CNT_W  = 5;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_PASS,
      ST_EDGE_I,
      ST_EDGE_J,
      ST_NORM,
      ST_SQ_X,
      ST_SQ_Y,
      ST_SQ_SUM,
      ST_SQRT,
      ST_DIV_X,
      ST_DIV_X_WAIT,
      ST_DIV_Y,
      ST_DIV_Y_WAIT,
      ST_PRJ_RD,
      ST_PRJ_MX,
      ST_PRJ_MY,
      ST_PRJ_ACC,
      ST_EVAL,
      ST_NEXT_EDGE,
      ST_FINISH,
      ST_DIR_X,
      ST_DIR_Y,
      ST_DIR_SUM,
      ST_OUT
   } state_type;

   // start/done handshake of an iterative unit
   typedef struct packed {
      logic start;
   } unit_req_type;

   typedef struct packed {
      logic done;
   } unit_rsp_type;

endpackage

`default_nettype wire

[sv/sat_sqrt.sv]
`timescale 1ns / 1ps
`default_nettype none

module sat_sqrt (
   input  wire                             clock,
   input  wire                             reset,
   input  sat_pkg::unit_req_type           req,
   input  wire [sat_pkg::SQRT_IN_W-1:0]    radicand,
   output sat_pkg::unit_rsp_type           rsp,
   output logic [sat_pkg::ROOT_W-1:0]      root
);
   import sat_pkg::*;

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [STEP_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [SQRT_IN_W-1:0]    rad_ff, rad_in;
   logic [31:0]             rem_ff, rem_in;
   logic [ROOT_W-1:0]       root_ff, root_in;
   logic [33:0]             rem_sh;
   logic [33:0]             trial;

   // two radicand bits per step, one root bit out
   always_comb begin
      rem_sh  = {rem_ff, rad_ff[SQRT_IN_W-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in = {rad_ff[SQRT_IN_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = 32'(rem_sh - trial);
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[31:0];
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + STEP_CNT_W'(1);
         if (cnt_ff == STEP_CNT_W'(SQRT_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign rsp.done = done_ff;
   assign root     = root_ff;

endmodule

`default_nettype wire

[sv/sat_div.sv]
`timescale 1ns / 1ps
`default_nettype none

module sat_div (
   input  wire                             clock,
   input  wire                             reset,
   input  sat_pkg::unit_req_type           req,
   input  wire [sat_pkg::DIV_NUM_W-1:0]    num,
   input  wire [sat_pkg::DIV_DEN_W-1:0]    den,
   output sat_pkg::unit_rsp_type           rsp,
   output logic [sat_pkg::QUO_W-1:0]       quo
);
   import sat_pkg::*;

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [STEP_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [DIV_DEN_W-1:0]    rem_ff, rem_in;
   logic [DIV_DEN_W-1:0]    den_ff, den_in;
   logic [QUO_W-1:0]        low_ff, low_in;
   logic [QUO_W-1:0]        quo_ff, quo_in;
   logic [DIV_DEN_W:0]      rem_sh;

   // restoring divide; upper numerator bits start below the divisor
   always_comb begin
      rem_sh  = {rem_ff, low_ff[QUO_W-1]};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = DIV_DEN_W'(num[DIV_NUM_W-1:QUO_W]);
         low_in  = num[QUO_W-1:0];
         den_in  = den;
         quo_in  = '0;
      end else if (busy_ff) begin
         low_in = {low_ff[QUO_W-2:0], 1'b0};
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = DIV_DEN_W'(rem_sh - {1'b0, den_ff});
            quo_in = {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DIV_DEN_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + STEP_CNT_W'(1);
         if (cnt_ff == STEP_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
   end

   assign rsp.done = done_ff;
   assign quo      = quo_ff;

endmodule

`default_nettype wire

[sv/sat_polygon_collision_unit.sv]
// vertex and centre loads are taken while idle, and the block stays ready for the next load
// a run goes per edge through normalize, sqrt, two divides and the projection of both
//    polygons on the shared multiplier, summed over the edges of both polygons, and then
//    finishes; with many vertices the projection loop sets most of the run time; a
//    separating axis ends the run early
// one result transfer per run; the block takes no new item until it is taken
// reset (synchronous, active high) clears both vertex counts and the centre of A
`timescale 1ns / 1ps
`default_nettype none

module sat_polygon_collision_unit #(
   parameter int MAX_VERTICES = 16
) (
   input  wire         clock,
   input  wire         reset,
   // request channel
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire [63:0]  req_tdata,   // x [31:0], y [63:32]
   input  wire [1:0]   req_tuser,   // kind [1:0]
   // result channel
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [71:0] rsp_tdata    // collides [0], axis_x [16:1], axis_y [32:17],
                                    // depth [64:33], zero [71:65]
);
   import sat_pkg::*;

   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam int IW = $clog2(MAX_VERTICES);

   // vertex stores, {y, x} per entry
   logic [2*COORD_W-1:0] mem_a [MAX_VERTICES];
   logic [2*COORD_W-1:0] mem_b [MAX_VERTICES];
   logic [2*COORD_W-1:0] a_q_ff, b_q_ff;
   logic [IW-1:0]        rd_addr;

   state_type state_ff, state_in;

   logic [CW-1:0]  count_a_ff, count_a_in, count_b_ff, count_b_in;
   logic signed [COORD_W-1:0] ca_x_ff, ca_x_in, ca_y_ff, ca_y_in;
   logic signed [COORD_W-1:0] cb_x_ff, cb_x_in, cb_y_ff, cb_y_in;

   logic           pass_ff, pass_in;    // 0: edges of a, 1: edges of b
   logic           side_ff, side_in;    // 0: projecting the edge owner, 1: the other
   logic [IW-1:0]  i_ff, i_in, k_ff, k_in;
   logic [2*COORD_W-1:0] vi_ff, vi_in;
   logic [32:0]    ax_ff, ax_in, ay_ff, ay_in;
   logic           ex_neg_ff, ex_neg_in, ey_pos_ff, ey_pos_in;
   logic [SQRT_IN_W-1:0] sq_ff, sq_in;
   logic [ROOT_W-1:0]    len_ff, len_in;
   logic signed [NORM_W-1:0] nx_ff, nx_in, ny_ff, ny_in;
   logic signed [COORD_W-1:0] py_ff, py_in;
   logic signed [PROJ_W-1:0] acc_ff, acc_in, mn_ff, mn_in, mx_ff, mx_in;
   logic signed [PROJ_W-1:0] minp_ff, minp_in, maxp_ff, maxp_in;
   logic           sep_ff, sep_in;
   logic           found_ff, found_in;
   logic signed [OV_W-1:0] best_ov_ff, best_ov_in;
   logic signed [NORM_W-1:0] best_nx_ff, best_nx_in, best_ny_ff, best_ny_in;

   logic           res_col_ff, res_col_in;
   logic signed [NORM_W-1:0] res_nx_ff, res_nx_in, res_ny_ff, res_ny_in;
   logic [DEPTH_W-1:0] res_depth_ff, res_depth_in;

   // shared multiplier, product registered
   logic signed [32:0] mul_a;
   logic signed [30:0] mul_b;
   logic signed [63:0] prod_ff;

   unit_req_type sqrt_req, div_req;
   unit_rsp_type sqrt_rsp, div_rsp;
   logic [ROOT_W-1:0]    sqrt_root;
   logic [DIV_NUM_W-1:0] div_num;
   logic [QUO_W-1:0]     div_quo;

   // derived conditions
   logic           req_xfer, rsp_xfer;
   logic [1:0]     kind;
   logic signed [COORD_W-1:0] in_x, in_y;
   logic [CW-1:0]  np, nq, nside, i_next, k_next;
   logic [IW-1:0]  j_idx;
   logic [2*COORD_W-1:0] vtx_pass, vtx_side;
   logic signed [32:0] ex, ey;
   logic           edge_zero;
   logic [32:0]    mag_max;
   logic           norm_hi, norm_lo;
   logic signed [PROJ_W-1:0] dot;
   logic signed [PROJ_W-1:0] hi, lo;
   logic signed [OV_W-1:0]   ov;
   logic           last_vertex, last_edge;
   logic signed [QUO_W:0]    q_neg;
   logic signed [NORM_W:0]   nx_neg, ny_neg;
   logic [OV_W-16:0]         ov_shift;

   assign req_xfer = req_tvalid && req_tready;
   assign rsp_xfer = rsp_tvalid && rsp_tready;
   assign kind     = req_tuser;
   assign in_x     = req_tdata[31:0];
   assign in_y     = req_tdata[63:32];

   assign np       = pass_ff ? count_b_ff : count_a_ff;
   assign nq       = pass_ff ? count_a_ff : count_b_ff;
   assign nside    = side_ff ? nq : np;
   assign i_next   = CW'(i_ff) + CW'(1);
   assign k_next   = CW'(k_ff) + CW'(1);
   assign j_idx    = (i_next == np) ? '0 : i_ff + IW'(1);
   assign last_vertex = (k_next == nside);
   assign last_edge   = (i_next == np);

   assign vtx_pass = pass_ff ? b_q_ff : a_q_ff;
   assign vtx_side = (pass_ff ^ side_ff) ? b_q_ff : a_q_ff;

   // edge vector from vertex i to vertex j
   assign ex = $signed({vtx_pass[31], vtx_pass[31:0]}) - $signed({vi_ff[31], vi_ff[31:0]});
   assign ey = $signed({vtx_pass[63], vtx_pass[63:32]}) - $signed({vi_ff[63], vi_ff[63:32]});
   assign edge_zero = (ex == '0) && (ey == '0);

   // bring the larger magnitude into [2^29, 2^30)
   assign mag_max = (ax_ff > ay_ff) ? ax_ff : ay_ff;
   assign norm_hi = (mag_max[32:30] != 3'b000);
   assign norm_lo = !mag_max[29];

   assign dot = acc_ff + prod_ff[PROJ_W-1:0];
   assign hi  = (maxp_ff < mx_ff) ? maxp_ff : mx_ff;
   assign lo  = (minp_ff > mn_ff) ? minp_ff : mn_ff;
   assign ov  = OV_W'(hi) - OV_W'(lo);

   assign q_neg    = -$signed({1'b0, div_quo});
   assign nx_neg   = -$signed({best_nx_ff[NORM_W-1], best_nx_ff});
   assign ny_neg   = -$signed({best_ny_ff[NORM_W-1], best_ny_ff});
   assign ov_shift = best_ov_ff[OV_W-1:15];

   // x component uses |ey|, y component uses |ex|
   assign div_num = (state_ff == ST_DIV_X) ?
                    DIV_NUM_W'({ay_ff[29:0], 15'd0}) + DIV_NUM_W'(len_ff[ROOT_W-1:1]) :
                    DIV_NUM_W'({ax_ff[29:0], 15'd0}) + DIV_NUM_W'(len_ff[ROOT_W-1:1]);

   sat_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .req      (sqrt_req),
      .radicand (sq_in),
      .rsp      (sqrt_rsp),
      .root     (sqrt_root)
   );

   sat_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .num   (div_num),
      .den   (len_ff),
      .rsp   (div_rsp),
      .quo   (div_quo)
   );

   // stores: write on load transfers, registered read
   always_ff @(posedge clock) begin
      if (req_xfer && kind == KIND_VERT_A && count_a_ff < CW'(MAX_VERTICES)) begin
         mem_a[count_a_ff[IW-1:0]] <= {in_y, in_x};
      end
      if (req_xfer && kind == KIND_VERT_B && count_b_ff < CW'(MAX_VERTICES)) begin
         mem_b[count_b_ff[IW-1:0]] <= {in_y, in_x};
      end
      a_q_ff <= mem_a[rd_addr];
      b_q_ff <= mem_b[rd_addr];
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer && kind == KIND_RUN) state_in = ST_PASS;
         end
         ST_PASS: begin
            if (np == '0) state_in = pass_ff ? ST_FINISH : ST_PASS;
            else          state_in = ST_EDGE_I;
         end
         ST_EDGE_I:     state_in = ST_EDGE_J;
         ST_EDGE_J:     state_in = edge_zero ? ST_NEXT_EDGE : ST_NORM;
         ST_NORM: begin
            if (!norm_hi && !norm_lo) state_in = ST_SQ_X;
         end
         ST_SQ_X:       state_in = ST_SQ_Y;
         ST_SQ_Y:       state_in = ST_SQ_SUM;
         ST_SQ_SUM:     state_in = ST_SQRT;
         ST_SQRT: begin
            if (sqrt_rsp.done) state_in = ST_DIV_X;
         end
         ST_DIV_X:      state_in = ST_DIV_X_WAIT;
         ST_DIV_X_WAIT: begin
            if (div_rsp.done) state_in = ST_DIV_Y;
         end
         ST_DIV_Y:      state_in = ST_DIV_Y_WAIT;
         ST_DIV_Y_WAIT: begin
            if (div_rsp.done) state_in = ST_PRJ_RD;
         end
         ST_PRJ_RD:     state_in = ST_PRJ_MX;
         ST_PRJ_MX:     state_in = ST_PRJ_MY;
         ST_PRJ_MY:     state_in = ST_PRJ_ACC;
         ST_PRJ_ACC: begin
            if (!last_vertex)  state_in = ST_PRJ_RD;
            else if (side_ff)  state_in = ST_EVAL;
            else if (nq == '0) state_in = ST_FINISH;
            else               state_in = ST_PRJ_RD;
         end
         ST_EVAL:       state_in = (ov <= 0) ? ST_FINISH : ST_NEXT_EDGE;
         ST_NEXT_EDGE: begin
            if (last_edge && pass_ff) state_in = ST_FINISH;
            else                      state_in = ST_PASS;
         end
         ST_FINISH:     state_in = (!sep_ff && found_ff) ? ST_DIR_X : ST_OUT;
         ST_DIR_X:      state_in = ST_DIR_Y;
         ST_DIR_Y:      state_in = ST_DIR_SUM;
         ST_DIR_SUM:    state_in = ST_OUT;
         ST_OUT: begin
            if (rsp_xfer) state_in = ST_IDLE;
         end
         default:       state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_tready     = 1'b0;
      rsp_tvalid     = 1'b0;
      rd_addr        = i_ff;
      mul_a          = '0;
      mul_b          = '0;
      sqrt_req.start = 1'b0;
      div_req.start  = 1'b0;
      case (state_ff)
         ST_IDLE:   req_tready = 1'b1;
         ST_PASS:   rd_addr = i_ff;
         ST_EDGE_I: rd_addr = j_idx;
         ST_SQ_X: begin
            mul_a = $signed({3'b000, ax_ff[29:0]});
            mul_b = $signed({1'b0, ax_ff[29:0]});
         end
         ST_SQ_Y: begin
            mul_a = $signed({3'b000, ay_ff[29:0]});
            mul_b = $signed({1'b0, ay_ff[29:0]});
         end
         ST_SQ_SUM: sqrt_req.start = 1'b1;
         ST_DIV_X:  div_req.start = 1'b1;
         ST_DIV_Y:  div_req.start = 1'b1;
         ST_PRJ_RD: rd_addr = k_ff;
         ST_PRJ_MX: begin
            mul_a = 33'($signed(vtx_side[31:0]));
            mul_b = 31'(nx_ff);
         end
         ST_PRJ_MY: begin
            mul_a = 33'(py_ff);
            mul_b = 31'(ny_ff);
         end
         ST_DIR_X: begin
            mul_a = 33'(cb_x_ff) - 33'(ca_x_ff);
            mul_b = 31'(best_nx_ff);
         end
         ST_DIR_Y: begin
            mul_a = 33'(cb_y_ff) - 33'(ca_y_ff);
            mul_b = 31'(best_ny_ff);
         end
         ST_OUT:    rsp_tvalid = 1'b1;
         default: begin
            rd_addr = i_ff;
         end
      endcase
   end

   // datapath registers
   always_comb begin
      count_a_in   = count_a_ff;
      count_b_in   = count_b_ff;
      ca_x_in      = ca_x_ff;
      ca_y_in      = ca_y_ff;
      cb_x_in      = cb_x_ff;
      cb_y_in      = cb_y_ff;
      pass_in      = pass_ff;
      side_in      = side_ff;
      i_in         = i_ff;
      k_in         = k_ff;
      vi_in        = vi_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      ex_neg_in    = ex_neg_ff;
      ey_pos_in    = ey_pos_ff;
      sq_in        = sq_ff;
      len_in       = len_ff;
      nx_in        = nx_ff;
      ny_in        = ny_ff;
      py_in        = py_ff;
      acc_in       = acc_ff;
      mn_in        = mn_ff;
      mx_in        = mx_ff;
      minp_in      = minp_ff;
      maxp_in      = maxp_ff;
      sep_in       = sep_ff;
      found_in     = found_ff;
      best_ov_in   = best_ov_ff;
      best_nx_in   = best_nx_ff;
      best_ny_in   = best_ny_ff;
      res_col_in   = res_col_ff;
      res_nx_in    = res_nx_ff;
      res_ny_in    = res_ny_ff;
      res_depth_in = res_depth_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               case (kind)
                  KIND_VERT_A: begin
                     if (count_a_ff < CW'(MAX_VERTICES)) count_a_in = count_a_ff + CW'(1);
                  end
                  KIND_VERT_B: begin
                     if (count_b_ff < CW'(MAX_VERTICES)) count_b_in = count_b_ff + CW'(1);
                  end
                  KIND_CENTRE_A: begin
                     ca_x_in = in_x;
                     ca_y_in = in_y;
                  end
                  default: begin
                     cb_x_in  = in_x;
                     cb_y_in  = in_y;
                     pass_in  = 1'b0;
                     i_in     = '0;
                     sep_in   = 1'b0;
                     found_in = 1'b0;
                  end
               endcase
            end
         end
         ST_PASS: begin
            // a polygon with no vertices has no edges to test
            if (np == '0 && !pass_ff) pass_in = 1'b1;
         end
         ST_EDGE_I: vi_in = vtx_pass;
         ST_EDGE_J: begin
            ax_in     = ex[32] ? 33'(-ex) : 33'(ex);
            ay_in     = ey[32] ? 33'(-ey) : 33'(ey);
            ex_neg_in = ex[32];
            ey_pos_in = !ey[32] && (ey != '0);
         end
         ST_NORM: begin
            if (norm_hi) begin
               ax_in = ax_ff >> 1;
               ay_in = ay_ff >> 1;
            end else if (norm_lo) begin
               ax_in = ax_ff << 1;
               ay_in = ay_ff << 1;
            end
         end
         ST_SQ_Y:   sq_in = SQRT_IN_W'(prod_ff);
         ST_SQ_SUM: sq_in = sq_ff + SQRT_IN_W'(prod_ff);
         ST_SQRT: begin
            if (sqrt_rsp.done) len_in = sqrt_root;
         end
         ST_DIV_X_WAIT: begin
            if (div_rsp.done) begin
               if (ey_pos_ff)                      nx_in = NORM_W'(q_neg);
               else if (div_quo > QUO_W'(32767))   nx_in = NORM_W'(32767);
               else                                nx_in = NORM_W'(div_quo);
            end
         end
         ST_DIV_Y_WAIT: begin
            if (div_rsp.done) begin
               if (ex_neg_ff)                      ny_in = NORM_W'(q_neg);
               else if (div_quo > QUO_W'(32767))   ny_in = NORM_W'(32767);
               else                                ny_in = NORM_W'(div_quo);
               side_in = 1'b0;
               k_in    = '0;
            end
         end
         ST_PRJ_MX: py_in  = $signed(vtx_side[63:32]);
         ST_PRJ_MY: acc_in = prod_ff[PROJ_W-1:0];
         ST_PRJ_ACC: begin
            if (k_ff == '0 || dot < mn_ff) mn_in = dot;
            if (k_ff == '0 || dot > mx_ff) mx_in = dot;
            if (!last_vertex) begin
               k_in = k_ff + IW'(1);
            end else if (!side_ff) begin
               minp_in = (k_ff == '0 || dot < mn_ff) ? dot : mn_ff;
               maxp_in = (k_ff == '0 || dot > mx_ff) ? dot : mx_ff;
               side_in = 1'b1;
               k_in    = '0;
               // empty other polygon separates on any tested axis
               if (nq == '0) sep_in = 1'b1;
            end
         end
         ST_EVAL: begin
            if (ov <= 0) begin
               sep_in = 1'b1;
            end else if (!found_ff || ov < best_ov_ff) begin
               found_in   = 1'b1;
               best_ov_in = ov;
               best_nx_in = nx_ff;
               best_ny_in = ny_ff;
            end
         end
         ST_NEXT_EDGE: begin
            if (last_edge) begin
               i_in = '0;
               if (!pass_ff) pass_in = 1'b1;
            end else begin
               i_in = i_ff + IW'(1);
            end
         end
         ST_FINISH: begin
            count_a_in = '0;
            count_b_in = '0;
            res_nx_in  = '0;
            res_ny_in  = '0;
            if (sep_ff) begin
               res_col_in   = 1'b0;
               res_depth_in = '0;
            end else begin
               res_col_in   = 1'b1;
               res_depth_in = '1;
            end
         end
         ST_DIR_Y: acc_in = prod_ff[PROJ_W-1:0];
         ST_DIR_SUM: begin
            // flip the normal so it points from a to b
            if (dot < 0) begin
               res_nx_in = (nx_neg > 17'sd32767) ? NORM_W'(32767) : NORM_W'(nx_neg);
               res_ny_in = (ny_neg > 17'sd32767) ? NORM_W'(32767) : NORM_W'(ny_neg);
            end else begin
               res_nx_in = best_nx_ff;
               res_ny_in = best_ny_ff;
            end
            if (ov_shift[OV_W-16:DEPTH_W] != '0) res_depth_in = '1;
            else                                 res_depth_in = ov_shift[DEPTH_W-1:0];
         end
         default: begin
            res_col_in = res_col_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_a_ff <= '0;
         count_b_ff <= '0;
         ca_x_ff    <= '0;
         ca_y_ff    <= '0;
         pass_ff    <= 1'b0;
         side_ff    <= 1'b0;
         i_ff       <= '0;
         k_ff       <= '0;
         sep_ff     <= 1'b0;
         found_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_a_ff <= count_a_in;
         count_b_ff <= count_b_in;
         ca_x_ff    <= ca_x_in;
         ca_y_ff    <= ca_y_in;
         pass_ff    <= pass_in;
         side_ff    <= side_in;
         i_ff       <= i_in;
         k_ff       <= k_in;
         sep_ff     <= sep_in;
         found_ff   <= found_in;
      end
      cb_x_ff      <= cb_x_in;
      cb_y_ff      <= cb_y_in;
      vi_ff        <= vi_in;
      ax_ff        <= ax_in;
      ay_ff        <= ay_in;
      ex_neg_ff    <= ex_neg_in;
      ey_pos_ff    <= ey_pos_in;
      sq_ff        <= sq_in;
      len_ff       <= len_in;
      nx_ff        <= nx_in;
      ny_ff        <= ny_in;
      py_ff        <= py_in;
      acc_ff       <= acc_in;
      mn_ff        <= mn_in;
      mx_ff        <= mx_in;
      minp_ff      <= minp_in;
      maxp_ff      <= maxp_in;
      best_ov_ff   <= best_ov_in;
      best_nx_ff   <= best_nx_in;
      best_ny_ff   <= best_ny_in;
      res_col_ff   <= res_col_in;
      res_nx_ff    <= res_nx_in;
      res_ny_ff    <= res_ny_in;
      res_depth_ff <= res_depth_in;
   end

   assign rsp_tdata = {7'd0, res_depth_ff, res_ny_ff, res_nx_ff, res_col_ff};

endmodule

`default_nettype wire
